[design/rtpl_pkg.sv]
// ----------------------------------------------------------------------------
// rtpl_pkg
// shared types and codes for the route table prefix lookup block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtpl_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_LOOKUP,
    OP_NOP
  } op_kind_t;

  // one queued operation; key is the route network or the lookup address
  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] key;
    logic [31:0] mask;
    logic [15:0] metric;
    logic [7:0]  iface;
  } op_t;

  // one stored route
  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [15:0] metric;
    logic [7:0]  iface;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } st_t;

endpackage

[design/rtpl_ram.sv]
// ----------------------------------------------------------------------------
// rtpl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/rtpl_front.sv]
// ----------------------------------------------------------------------------
// rtpl_front
// accepts input beats, decodes the command and queues the operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_cmd,
  input  logic [31:0]    in_route_net,
  input  logic [31:0]    in_route_mask,
  input  logic [15:0]    in_route_metric,
  input  logic [7:0]     in_route_iface,
  input  logic           in_route_up,
  input  logic [31:0]    in_lookup_addr,
  output logic           q_valid,
  output rtpl_pkg::op_t  q_item,
  input  logic           q_pop
);

  rtpl_pkg::op_t             q_mem_r [rtpl_pkg::QDEPTH];
  logic [rtpl_pkg::QAW-1:0]  wr_ptr_r;
  logic [rtpl_pkg::QAW-1:0]  rd_ptr_r;
  logic [rtpl_pkg::QAW:0]    cnt_r;
  rtpl_pkg::op_t             op_dec;
  logic                      push;
  logic                      pop;

  // decode: an insert of a route that is down becomes a no-op and stores nothing
  always_comb begin
    op_dec.key    = in_route_net;
    op_dec.mask   = in_route_mask;
    op_dec.metric = in_route_metric;
    op_dec.iface  = in_route_iface;
    unique case (in_cmd)
      rtpl_pkg::CMD_CLEAR:  op_dec.kind = rtpl_pkg::OP_CLEAR;
      rtpl_pkg::CMD_INSERT: op_dec.kind = in_route_up ? rtpl_pkg::OP_INSERT
                                                      : rtpl_pkg::OP_NOP;
      rtpl_pkg::CMD_LOOKUP: begin
        op_dec.kind = rtpl_pkg::OP_LOOKUP;
        op_dec.key  = in_lookup_addr;
      end
      default:              op_dec.kind = rtpl_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (cnt_r == (rtpl_pkg::QAW+1)'(rtpl_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[design/rtpl_back.sv]
// ----------------------------------------------------------------------------
// rtpl_back
// executes queued operations against the route ram and drives the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpl_back #(
  parameter int MAX_ROUTES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rtpl_pkg::op_t  q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_match_found,
  output logic [7:0]     out_out_iface,
  output logic           out_status
);

  localparam int CW = $clog2(MAX_ROUTES + 1);
  localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;

  rtpl_pkg::st_t     state_r;
  rtpl_pkg::st_t     state_nxt;
  logic [CW-1:0]     cnt_r;
  logic [AW-1:0]     idx_r;
  logic [31:0]       key_r;
  logic              rd_pend_r;
  logic              found_r;
  logic [31:0]       best_mask_r;
  logic [15:0]       best_metric_r;
  logic [7:0]        best_iface_r;
  logic              status_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [7:0]        out_iface_r;
  logic              out_status_r;

  logic              full;
  logic              last;
  logic              ram_we;
  logic              ram_re;
  logic              emit_go;
  rtpl_pkg::entry_t  wr_entry;
  rtpl_pkg::entry_t  rd_entry;
  logic              hit;
  logic              better;

  assign full = (cnt_r == CW'(MAX_ROUTES));
  assign last = ((CW'(idx_r) + CW'(1)) == cnt_r);

  assign wr_entry.net    = q_item.key;
  assign wr_entry.mask   = q_item.mask;
  assign wr_entry.metric = q_item.metric;
  assign wr_entry.iface  = q_item.iface;

  rtpl_ram #(
    .WIDTH (rtpl_pkg::ENTRY_W),
    .DEPTH (MAX_ROUTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtpl_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == rtpl_pkg::OP_LOOKUP && cnt_r != '0) begin
            state_nxt = rtpl_pkg::ST_SCAN;
          end else begin
            state_nxt = rtpl_pkg::ST_EMIT;
          end
        end
      end
      rtpl_pkg::ST_SCAN: begin
        if (last) begin
          state_nxt = rtpl_pkg::ST_DRAIN;
        end
      end
      rtpl_pkg::ST_DRAIN: state_nxt = rtpl_pkg::ST_EMIT;
      rtpl_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = rtpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rtpl_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop   = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    emit_go = 1'b0;
    unique case (state_r)
      rtpl_pkg::ST_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && (q_item.kind == rtpl_pkg::OP_INSERT) && !full;
      end
      rtpl_pkg::ST_SCAN:  ram_re = 1'b1;
      rtpl_pkg::ST_DRAIN: ;
      rtpl_pkg::ST_EMIT:  emit_go = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // compare stage on the registered ram word
  assign hit    = ((key_r & rd_entry.mask) == rd_entry.net);
  assign better = !found_r || (rd_entry.mask > best_mask_r) ||
                  ((rd_entry.mask == best_mask_r) && (rd_entry.metric < best_metric_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtpl_pkg::ST_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= ram_re;
      if (q_pop) begin
        found_r <= 1'b0;
        if (q_item.kind == rtpl_pkg::OP_CLEAR) begin
          cnt_r <= '0;
        end else if (ram_we) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (rd_pend_r && hit && better) begin
        found_r <= 1'b1;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r        <= q_item.key;
      idx_r        <= '0;
      best_iface_r <= '0;
      status_r     <= (q_item.kind == rtpl_pkg::OP_INSERT) && full;
    end else begin
      if (ram_re) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rd_pend_r && hit && better) begin
        best_mask_r   <= rd_entry.mask;
        best_metric_r <= rd_entry.metric;
        best_iface_r  <= rd_entry.iface;
      end
    end
    if (emit_go) begin
      out_found_r  <= found_r;
      out_iface_r  <= best_iface_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_found_r;
  assign out_out_iface   = out_iface_r;
  assign out_status      = out_status_r;

endmodule

[design/route_table_prefix_lookup_core.sv]
// ----------------------------------------------------------------------------
// route_table_prefix_lookup_core
// a lookup scans all N stored routes, with one ram read per entry
// a lookup on an empty table, clear, insert and ignored commands skip the scan
// a stalled result beat holds the back end until it is taken
// a two-beat queue lets input beats be taken while the back end is busy
// reset empties the table and the queue; route storage is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module route_table_prefix_lookup_core #(
  parameter int MAX_ROUTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_route_net,
  input  logic [31:0] in_route_mask,
  input  logic [15:0] in_route_metric,
  input  logic [7:0]  in_route_iface,
  input  logic        in_route_up,
  input  logic [31:0] in_lookup_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match_found,
  output logic [7:0]  out_out_iface,
  output logic        out_status
);

  logic           q_valid;
  logic           q_pop;
  rtpl_pkg::op_t  q_item;

  rtpl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_route_net    (in_route_net),
    .in_route_mask   (in_route_mask),
    .in_route_metric (in_route_metric),
    .in_route_iface  (in_route_iface),
    .in_route_up     (in_route_up),
    .in_lookup_addr  (in_lookup_addr),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  rtpl_back #(
    .MAX_ROUTES (MAX_ROUTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_found (out_match_found),
    .out_out_iface   (out_out_iface),
    .out_status      (out_status)
  );

endmodule
